[design/wsd_pkg.sv]
// shared types and constants for the websocket frame deframer
// no dependencies; compile first
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HDR = 3'd0,
		PH_LEN = 3'd1,
		PH_EXT = 3'd2,
		PH_KEY = 3'd3,
		PH_PAY = 3'd4
	} wsd_phase_t;

	localparam logic [6:0] LEN16_CODE  = 7'd126;
	localparam logic [6:0] LEN64_CODE  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] OP_CONT     = 4'd0;
	localparam logic [1:0] KEY_LAST    = 2'd3;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_data;
		logic [3:0] msg_opcode;
		logic       frame_end;
		logic       message_end;
		logic       discard_partial;
	} wsd_result_t;

endpackage

[design/wsd_ifs.sv]
// valid/ready channel interfaces for received bytes and deframed results
// no dependencies
interface wsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_data;
	logic [3:0] msg_opcode;
	logic       frame_end;
	logic       message_end;
	logic       discard_partial;

	modport source (output valid, output payload_byte, output has_data, output msg_opcode,
		output frame_end, output message_end, output discard_partial, input ready);
	modport sink (input valid, input payload_byte, input has_data, input msg_opcode,
		input frame_end, input message_end, input discard_partial, output ready);
endinterface

[design/websocket_frame_deframer.sv]
// websocket frame deframer: one received byte per cycle in, results out
// a result is registered in the result buffer when its byte is taken
// throughput: one byte per cycle; a two-entry result buffer keeps input ready while
// one result waits, input stalls only when both entries are held
// reset: arst_n asynchronous, parser returns to the header phase, buffer empties
module websocket_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	wsd_byte_if.sink     stream,
	wsd_result_if.source frames
);
	import wsd_pkg::*;

	logic        in_fire;
	logic        buf_full;
	logic        res_valid;
	wsd_result_t res;

	assign stream.ready = !buf_full;
	assign in_fire      = stream.valid && !buf_full;

	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.rx_byte   (stream.rx_byte),
		.res_valid (res_valid),
		.res       (res)
	);

	wsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.frames    (frames)
	);

endmodule

[design/wsd_parser.sv]
// frame header parser and payload unmasking, one byte per accepted item
// depends on wsd_pkg
module wsd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [7:0]          rx_byte,
	output logic                res_valid,
	output wsd_pkg::wsd_result_t res
);
	import wsd_pkg::*;

	wsd_phase_t  phase_q, phase_d;
	logic [3:0]  ext_q, ext_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  mpos_q, mpos_d;
	logic        fin_q, fin_d;
	logic        masked_q, masked_d;
	logic [3:0]  op_q, op_d;
	logic [3:0]  frag_op_q, frag_op_d;
	logic        frag_open_q, frag_open_d;

	logic [6:0]  len7;
	logic [63:0] rem_shift;
	logic [3:0]  ext_dec;
	logic        emit_v, emit_last;
	logic [7:0]  emit_byte;
	logic        start_frag;

	assign len7       = rx_byte[6:0];
	assign rem_shift  = {rem_q[55:0], rx_byte};
	assign ext_dec    = 4'(ext_q - 4'd1);
	assign start_frag = !fin_q && (op_q != OP_CONT);

	// which bytes produce a result
	always_comb begin
		emit_v    = 1'b0;
		emit_last = 1'b1;
		emit_byte = 8'd0;
		case (phase_q)
			PH_LEN: begin
				emit_v = (len7 == 7'd0) && !rx_byte[7];
			end
			PH_EXT: begin
				emit_v = (ext_dec == 4'd0) && !masked_q && (rem_shift == 64'd0);
			end
			PH_KEY: begin
				emit_v = (mpos_q == KEY_LAST) && (rem_q == 64'd0);
			end
			PH_PAY: begin
				emit_v    = 1'b1;
				emit_last = (rem_q == 64'd1);
				emit_byte = rx_byte ^ (masked_q ? key_q[{~mpos_q, 3'b000} +: 8] : 8'd0);
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d     = phase_q;
		ext_d       = ext_q;
		rem_d       = rem_q;
		key_d       = key_q;
		mpos_d      = mpos_q;
		fin_d       = fin_q;
		masked_d    = masked_q;
		op_d        = op_q;
		frag_op_d   = frag_op_q;
		frag_open_d = frag_open_q;
		case (phase_q)
			PH_LEN: begin
				masked_d = rx_byte[7];
				rem_d    = 64'd0;
				if (len7 == LEN16_CODE) begin
					ext_d   = EXT16_BYTES;
					phase_d = PH_EXT;
				end else if (len7 == LEN64_CODE) begin
					ext_d   = EXT64_BYTES;
					phase_d = PH_EXT;
				end else begin
					rem_d  = {57'd0, len7};
					mpos_d = 2'd0;
					if (rx_byte[7]) begin
						key_d   = 32'd0;
						phase_d = PH_KEY;
					end else begin
						phase_d = PH_PAY;
					end
				end
			end
			PH_EXT: begin
				rem_d = rem_shift;
				ext_d = ext_dec;
				if (ext_dec == 4'd0) begin
					mpos_d = 2'd0;
					if (masked_q) begin
						key_d   = 32'd0;
						phase_d = PH_KEY;
					end else begin
						phase_d = PH_PAY;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				if (mpos_q != KEY_LAST) begin
					mpos_d = 2'(mpos_q + 2'd1);
				end else begin
					mpos_d  = 2'd0;
					phase_d = PH_PAY;
				end
			end
			PH_PAY: begin
				mpos_d = 2'(mpos_q + 2'd1);
				rem_d  = 64'(rem_q - 64'd1);
			end
			default: begin
				fin_d   = rx_byte[7];
				op_d    = rx_byte[3:0];
				ext_d   = 4'd0;
				mpos_d  = 2'd0;
				phase_d = PH_LEN;
			end
		endcase
		// end of frame closes the frame and updates fragment bookkeeping
		if (emit_v && emit_last) begin
			phase_d = PH_HDR;
			mpos_d  = 2'd0;
			if (start_frag) begin
				frag_open_d = 1'b1;
				frag_op_d   = op_q;
			end else if (fin_q && (op_q == OP_CONT)) begin
				frag_open_d = 1'b0;
			end
		end
	end

	// result fields
	always_comb begin
		res_valid           = in_fire && emit_v;
		res.payload_byte    = emit_byte;
		res.has_data        = (phase_q == PH_PAY);
		res.msg_opcode      = (op_q != OP_CONT) ? op_q : frag_op_q;
		res.frame_end       = emit_last;
		res.message_end     = emit_last && fin_q;
		res.discard_partial = start_frag && frag_open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR;
			ext_q       <= 4'd0;
			rem_q       <= 64'd0;
			key_q       <= 32'd0;
			mpos_q      <= 2'd0;
			fin_q       <= 1'b0;
			masked_q    <= 1'b0;
			op_q        <= 4'd0;
			frag_op_q   <= 4'd0;
			frag_open_q <= 1'b0;
		end else if (in_fire) begin
			phase_q     <= phase_d;
			ext_q       <= ext_d;
			rem_q       <= rem_d;
			key_q       <= key_d;
			mpos_q      <= mpos_d;
			fin_q       <= fin_d;
			masked_q    <= masked_d;
			op_q        <= op_d;
			frag_op_q   <= frag_op_d;
			frag_open_q <= frag_open_d;
		end
	end

`ifndef ASSERT_OFF
	a_len_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (phase_q == PH_EXT) && (ext_dec != 4'd0)) |-> !res_valid)
		else $error("result during extended length bytes");
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.has_data) |-> (res.payload_byte == 8'd0) && res.frame_end)
		else $error("empty marker carries data or does not end the frame");
	a_frame_end_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.frame_end) |=> (phase_q == PH_HDR))
		else $error("frame end did not return to header phase");
	a_open_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.frame_end && start_frag) |=> frag_open_q)
		else $error("start fragment did not open a message");
`endif

endmodule

[design/wsd_out_buf.sv]
// two-entry result buffer between the parser and the result channel
// depends on wsd_pkg and wsd_result_if
module wsd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wsd_pkg::wsd_result_t push_data,
	output logic                full,
	wsd_result_if.source        frames
);
	import wsd_pkg::*;

	wsd_result_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        pop;
	wsd_result_t head;

	assign full  = (cnt_q == 2'd2);
	assign pop   = frames.valid && frames.ready;
	assign head  = mem_q[rd_ptr_q];

	assign frames.valid           = (cnt_q != 2'd0);
	assign frames.payload_byte    = head.payload_byte;
	assign frames.has_data        = head.has_data;
	assign frames.msg_opcode      = head.msg_opcode;
	assign frames.frame_end       = head.frame_end;
	assign frames.message_end     = head.message_end;
	assign frames.discard_partial = head.discard_partial;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("buffer count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full buffer");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ while buffer empty");
`endif

endmodule
